@@ sv/assert_macros.svh @@
// assertion macros for the checker file sit_props
// no dependencies; callers provide clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sit assertion failed");

// next-cycle implication, off during reset
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sit assertion failed");

`endif

@@ sv/sit_pkg.sv @@
// constants, types and helpers for the seed index table insert block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sit_pkg;

  localparam int ROWS         = 32768;
  localparam int ROW_SLOTS    = 8;
  localparam int SEED_LETTERS = 3;

  localparam int LETTER_W    = 5;
  localparam int CODE_W      = LETTER_W * SEED_LETTERS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int SLOT_W      = $clog2(ROW_SLOTS);
  localparam int SA_W        = ROW_W + SLOT_W;
  localparam int SL_DEPTH    = ROWS * (2 ** SLOT_W);
  localparam int CNT_W       = 8;
  localparam int NUM_W       = 23;
  localparam int POS_W       = 23;
  localparam int WORD_W      = 24;
  localparam int SUM_W       = WORD_W + 1;
  localparam int STEP_W      = $clog2(ROWS + 2);
  // four spare levels always reach past the table for ROWS up to 2**15
  localparam int LVL_W       = 2;
  localparam int SPARE_FIRST = 26;
  localparam int SPARE_AREA  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [SA_W-1:0]       saddr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [ROW_W:0]        rend_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [2*WORD_W-1:0]   entry_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [LVL_W-1:0]      lvl_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;

  localparam cnt_t  COUNT_MAX  = cnt_t'(255);
  localparam cnt_t  SLOTS_CNT  = cnt_t'(ROW_SLOTS);
  localparam word_t LINK_MARK  = '1;
  localparam row_t  ROW_LAST   = row_t'(ROWS - 1);
  localparam rend_t ROWS_END   = rend_t'(ROWS);
  localparam sum_t  ROWS_SUM   = sum_t'(ROWS);
  localparam step_t ROWS_STEP  = step_t'(ROWS);
  localparam slot_t SLOT_LAST  = slot_t'(ROW_SLOTS - 1);
  localparam qcnt_t QUEUE_FULL = qcnt_t'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_INVALID  = 2'd1,
    ST_REPEATED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    row_t               home;
    logic               in_range;
    status_t            pre;
    logic [NUM_W-1:0]   num;
    logic [POS_W-1:0]   pos;
  } item_t;

  typedef struct packed {
    status_t status;
    row_t    row;
    slot_t   slot;
    cnt_t    home_count;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HOME_RD, S_HOME_CHK, S_LINK_RD, S_LINK_CHK,
    S_TAIL_RD, S_TAIL_CHK, S_LEVEL, S_SCAN_RD, S_SCAN_CHK, S_MOVE_LAST,
    S_SET_LINK, S_WR_HIT, S_WR_ROW, S_WR_HOME, S_DONE
  } state_t;

  function automatic cnt_t bump(input cnt_t c);
    bump = (c < COUNT_MAX) ? c + cnt_t'(1) : COUNT_MAX;
  endfunction

endpackage

@@ sv/sit_front.sv @@
// front part: takes items, classifies them and queues them for the back part
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [14:0]                seed_code,
  input  logic                       seed_invalid,
  input  logic [sit_pkg::NUM_W-1:0]  sequence_number,
  input  logic [sit_pkg::POS_W-1:0]  seed_position,
  input  logic                       cfg_write,
  input  logic                       skip_repeated_letters,
  input  logic                       clearing,
  input  logic                       q_pop,
  output logic                       q_empty,
  output sit_pkg::item_t             q_head
);

  logic                          skip_rep;
  logic [sit_pkg::CODE_W-1:0]    code;
  logic [31:0]                   code32;
  logic                          same;
  logic                          in_range;
  sit_pkg::item_t                item;
  sit_pkg::item_t                q [sit_pkg::QUEUE_DEPTH];
  sit_pkg::qptr_t                wp;
  sit_pkg::qptr_t                rp;
  sit_pkg::qcnt_t                cnt;
  logic                          accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_rep <= 1'b1;
    end else if (cfg_write) begin
      skip_rep <= skip_repeated_letters;
    end
  end

  always_comb begin
    code     = seed_code[sit_pkg::CODE_W-1:0];
    code32   = 32'(code);
    in_range = code32 < 32'(sit_pkg::ROWS);
    same     = skip_rep;
    for (int i = 1; i < sit_pkg::SEED_LETTERS; i++) begin
      if (code[sit_pkg::LETTER_W*(sit_pkg::SEED_LETTERS-1-i) +: sit_pkg::LETTER_W] !=
          code[sit_pkg::LETTER_W*(sit_pkg::SEED_LETTERS-1) +: sit_pkg::LETTER_W]) begin
        same = 1'b0;
      end
    end
    item.home     = code32[sit_pkg::ROW_W-1:0];
    item.in_range = in_range;
    item.num      = sequence_number;
    item.pos      = seed_position;
    if (seed_invalid) begin
      item.pre = sit_pkg::ST_INVALID;
    end else if (same) begin
      item.pre = sit_pkg::ST_REPEATED;
    end else if (!in_range) begin
      item.pre = sit_pkg::ST_FULL;
    end else begin
      item.pre = sit_pkg::ST_STORED;
    end
  end

  // no items are taken while the table is being cleared
  assign full    = clearing || (cnt == sit_pkg::QUEUE_FULL);
  assign accept  = push && !full;
  assign q_empty = (cnt == '0);
  assign q_head  = q[rp];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wp <= wp + sit_pkg::qptr_t'(1);
      end
      if (q_pop) begin
        rp <= rp + sit_pkg::qptr_t'(1);
      end
      cnt <= cnt + sit_pkg::qcnt_t'(accept) - sit_pkg::qcnt_t'(q_pop);
    end
  end

endmodule

@@ sv/sit_resq.sv @@
// result queue: holds finished results until the consumer pops them
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_resq (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  sit_pkg::result_t  res_data,
  output logic              res_full,
  input  logic              pop,
  output logic              empty,
  output sit_pkg::result_t  head
);

  sit_pkg::result_t  q [sit_pkg::QUEUE_DEPTH];
  sit_pkg::qptr_t    wp;
  sit_pkg::qptr_t    rp;
  sit_pkg::qcnt_t    cnt;
  logic              take;

  assign res_full = (cnt == sit_pkg::QUEUE_FULL);
  assign empty    = (cnt == '0);
  assign head     = q[rp];
  assign take     = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wp] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (res_push) begin
        wp <= wp + sit_pkg::qptr_t'(1);
      end
      if (take) begin
        rp <= rp + sit_pkg::qptr_t'(1);
      end
      cnt <= cnt + sit_pkg::qcnt_t'(res_push) - sit_pkg::qcnt_t'(take);
    end
  end

endmodule

@@ sv/sit_back.sv @@
// back part: sequencer that clears the tables after reset, then updates the row counts and slot table for one item
// depends on sit_pkg; owns the row count and slot memories
`timescale 1ns / 1ps

module sit_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  sit_pkg::item_t    q_head,
  output logic              q_pop,
  output logic              clearing,
  input  logic              res_full,
  output logic              res_push,
  output sit_pkg::result_t  res_data
);

  sit_pkg::state_t   state;
  sit_pkg::state_t   state_next;

  sit_pkg::cnt_t     rc_mem [sit_pkg::ROWS];
  sit_pkg::entry_t   sl_mem [sit_pkg::SL_DEPTH];
  sit_pkg::cnt_t     rc_rdata;
  sit_pkg::entry_t   sl_rdata;
  sit_pkg::row_t     rc_raddr;
  sit_pkg::row_t     rc_waddr;
  sit_pkg::cnt_t     rc_wdata;
  logic              rc_we;
  sit_pkg::saddr_t   sl_raddr;
  sit_pkg::saddr_t   sl_waddr;
  sit_pkg::entry_t   sl_wdata;
  logic              sl_we;

  sit_pkg::row_t     clr_row;
  sit_pkg::item_t    itm;
  sit_pkg::cnt_t     cnt_old;
  sit_pkg::cnt_t     newc;
  sit_pkg::row_t     tail;
  sit_pkg::step_t    steps;
  sit_pkg::word_t    last_num;
  sit_pkg::word_t    last_val;
  sit_pkg::lvl_t     level;
  sit_pkg::row_t     scan;
  sit_pkg::rend_t    scan_end;
  sit_pkg::row_t     spare;
  sit_pkg::row_t     hit_row;
  sit_pkg::slot_t    hit_slot;
  sit_pkg::cnt_t     row_cnt;
  sit_pkg::result_t  res;

  sit_pkg::cnt_t     newc_calc;
  sit_pkg::word_t    rd_num;
  sit_pkg::word_t    rd_val;
  sit_pkg::sum_t     link_sum;
  sit_pkg::step_t    steps_nx;
  logic              link_bad;
  logic [5:0]        sh_lo;
  logic [5:0]        sh_hi;
  logic [31:0]       home32;
  logic [31:0]       lvl_base;
  logic [31:0]       lvl_end;
  logic              lvl_none;
  sit_pkg::rend_t    lvl_end_cl;
  sit_pkg::rend_t    scan_nx;

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (rc_we) begin
      rc_mem[rc_waddr] <= rc_wdata;
    end
    rc_rdata <= rc_mem[rc_raddr];
  end

  always_ff @(posedge clk) begin
    if (sl_we) begin
      sl_mem[sl_waddr] <= sl_wdata;
    end
    sl_rdata <= sl_mem[sl_raddr];
  end

  always_comb begin
    newc_calc = sit_pkg::bump(rc_rdata);
    rd_num    = sl_rdata[2*sit_pkg::WORD_W-1:sit_pkg::WORD_W];
    rd_val    = sl_rdata[sit_pkg::WORD_W-1:0];
    // next row of the chain: tail plus a signed 24-bit distance
    link_sum  = sit_pkg::sum_t'(tail) + {rd_val[sit_pkg::WORD_W-1], rd_val};
    steps_nx  = steps + sit_pkg::step_t'(1);
    link_bad  = link_sum[sit_pkg::SUM_W-1] || (link_sum >= sit_pkg::ROWS_SUM) ||
                (steps_nx > sit_pkg::ROWS_STEP);
    // spare range of a level: letter at that level in 26..31
    home32    = 32'(itm.home);
    sh_lo     = 6'(level) * 6'(sit_pkg::LETTER_W);
    sh_hi     = sh_lo + 6'(sit_pkg::LETTER_W);
    lvl_base  = ((home32 >> sh_hi) << sh_hi) + (32'(sit_pkg::SPARE_FIRST) << sh_lo);
    lvl_end   = lvl_base + (32'(sit_pkg::SPARE_AREA) << sh_lo);
    lvl_none  = lvl_base >= 32'(sit_pkg::ROWS);
    lvl_end_cl = (lvl_end > 32'(sit_pkg::ROWS)) ? sit_pkg::ROWS_END
                                                : lvl_end[sit_pkg::ROW_W:0];
    scan_nx   = sit_pkg::rend_t'(scan) + sit_pkg::rend_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sit_pkg::S_CLEAR: begin
        if (clr_row == sit_pkg::ROW_LAST) state_next = sit_pkg::S_IDLE;
      end
      sit_pkg::S_IDLE: begin
        if (!q_empty) state_next = sit_pkg::S_HOME_RD;
      end
      sit_pkg::S_HOME_RD:  state_next = sit_pkg::S_HOME_CHK;
      sit_pkg::S_HOME_CHK: begin
        if (itm.pre != sit_pkg::ST_STORED) begin
          state_next = sit_pkg::S_DONE;
        end else if (newc_calc <= sit_pkg::SLOTS_CNT) begin
          state_next = sit_pkg::S_WR_HIT;
        end else begin
          state_next = sit_pkg::S_LINK_RD;
        end
      end
      sit_pkg::S_LINK_RD:  state_next = sit_pkg::S_LINK_CHK;
      sit_pkg::S_LINK_CHK: begin
        if (rd_num == sit_pkg::LINK_MARK) begin
          state_next = link_bad ? sit_pkg::S_DONE : sit_pkg::S_LINK_RD;
        end else if (tail == itm.home) begin
          state_next = sit_pkg::S_LEVEL;
        end else begin
          state_next = sit_pkg::S_TAIL_RD;
        end
      end
      sit_pkg::S_TAIL_RD:  state_next = sit_pkg::S_TAIL_CHK;
      sit_pkg::S_TAIL_CHK: begin
        state_next = (rc_rdata >= sit_pkg::SLOTS_CNT) ? sit_pkg::S_LEVEL : sit_pkg::S_WR_HIT;
      end
      sit_pkg::S_LEVEL: begin
        state_next = lvl_none ? sit_pkg::S_DONE : sit_pkg::S_SCAN_RD;
      end
      sit_pkg::S_SCAN_RD:  state_next = sit_pkg::S_SCAN_CHK;
      sit_pkg::S_SCAN_CHK: begin
        if (rc_rdata == '0) begin
          state_next = sit_pkg::S_MOVE_LAST;
        end else if (scan_nx >= scan_end) begin
          state_next = sit_pkg::S_LEVEL;
        end else begin
          state_next = sit_pkg::S_SCAN_RD;
        end
      end
      sit_pkg::S_MOVE_LAST: state_next = sit_pkg::S_SET_LINK;
      sit_pkg::S_SET_LINK:  state_next = sit_pkg::S_WR_HIT;
      sit_pkg::S_WR_HIT: begin
        state_next = (hit_row != itm.home) ? sit_pkg::S_WR_ROW : sit_pkg::S_WR_HOME;
      end
      sit_pkg::S_WR_ROW:  state_next = sit_pkg::S_WR_HOME;
      sit_pkg::S_WR_HOME: state_next = sit_pkg::S_DONE;
      sit_pkg::S_DONE: begin
        if (!res_full) state_next = sit_pkg::S_IDLE;
      end
      default: state_next = sit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    clearing = 1'b0;
    res_push = 1'b0;
    rc_raddr = itm.home;
    rc_we    = 1'b0;
    rc_waddr = itm.home;
    rc_wdata = newc;
    sl_raddr = {tail, sit_pkg::SLOT_LAST};
    sl_we    = 1'b0;
    sl_waddr = {hit_row, hit_slot};
    sl_wdata = {sit_pkg::word_t'(itm.num), sit_pkg::word_t'(itm.pos)};
    case (state)
      sit_pkg::S_CLEAR: begin
        clearing = 1'b1;
        rc_we    = 1'b1;
        rc_waddr = clr_row;
        rc_wdata = '0;
        // only the last slot of a row is ever read back
        sl_we    = 1'b1;
        sl_waddr = {clr_row, sit_pkg::SLOT_LAST};
        sl_wdata = '0;
      end
      sit_pkg::S_IDLE:    q_pop = !q_empty;
      sit_pkg::S_TAIL_RD: rc_raddr = tail;
      sit_pkg::S_SCAN_RD: rc_raddr = scan;
      sit_pkg::S_MOVE_LAST: begin
        sl_we    = 1'b1;
        sl_waddr = {spare, sit_pkg::slot_t'(0)};
        sl_wdata = {last_num, last_val};
      end
      sit_pkg::S_SET_LINK: begin
        sl_we    = 1'b1;
        sl_waddr = {tail, sit_pkg::SLOT_LAST};
        sl_wdata = {sit_pkg::LINK_MARK,
                    sit_pkg::word_t'(spare) - sit_pkg::word_t'(tail)};
      end
      sit_pkg::S_WR_HIT: sl_we = 1'b1;
      sit_pkg::S_WR_ROW: begin
        rc_we    = 1'b1;
        rc_waddr = hit_row;
        rc_wdata = row_cnt;
      end
      sit_pkg::S_WR_HOME: rc_we = 1'b1;
      sit_pkg::S_DONE:    res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == sit_pkg::S_CLEAR) begin
      clr_row <= clr_row + sit_pkg::row_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sit_pkg::S_IDLE: begin
        if (!q_empty) itm <= q_head;
      end
      sit_pkg::S_HOME_CHK: begin
        cnt_old  <= rc_rdata;
        newc     <= newc_calc;
        tail     <= itm.home;
        steps    <= '0;
        level    <= '0;
        hit_row  <= itm.home;
        hit_slot <= sit_pkg::slot_t'(newc_calc - sit_pkg::cnt_t'(1));
        res.status     <= itm.pre;
        res.row        <= '0;
        res.slot       <= '0;
        res.home_count <= itm.in_range ? rc_rdata : '0;
      end
      sit_pkg::S_LINK_CHK: begin
        if (rd_num == sit_pkg::LINK_MARK) begin
          steps <= steps_nx;
          tail  <= link_sum[sit_pkg::ROW_W-1:0];
          if (link_bad) begin
            res.status     <= sit_pkg::ST_FULL;
            res.home_count <= cnt_old;
          end
        end else begin
          last_num <= rd_num;
          last_val <= rd_val;
        end
      end
      sit_pkg::S_TAIL_CHK: begin
        hit_row  <= tail;
        hit_slot <= sit_pkg::slot_t'(rc_rdata);
        row_cnt  <= sit_pkg::bump(rc_rdata);
      end
      sit_pkg::S_LEVEL: begin
        scan     <= lvl_base[sit_pkg::ROW_W-1:0];
        scan_end <= lvl_end_cl;
        if (lvl_none) begin
          res.status     <= sit_pkg::ST_FULL;
          res.home_count <= cnt_old;
        end
      end
      sit_pkg::S_SCAN_CHK: begin
        if (rc_rdata == '0) begin
          spare <= scan;
        end else if (scan_nx >= scan_end) begin
          level <= level + sit_pkg::lvl_t'(1);
        end else begin
          scan <= scan_nx[sit_pkg::ROW_W-1:0];
        end
      end
      sit_pkg::S_SET_LINK: begin
        // moved entry sits in slot 0, the new hit goes after it
        hit_row  <= spare;
        hit_slot <= sit_pkg::slot_t'(1);
        row_cnt  <= sit_pkg::bump(sit_pkg::cnt_t'(1));
      end
      sit_pkg::S_WR_HOME: begin
        res.status     <= sit_pkg::ST_STORED;
        res.row        <= hit_row;
        res.slot       <= hit_slot;
        res.home_count <= newc;
      end
      default: ;
    endcase
  end

  assign res_data = res;

endmodule

@@ sv/seed_index_table_insert.sv @@
// Seed hit table insert block. After reset the block clears its tables one
// row per cycle and holds full high meanwhile. Items are then handled one at
// a time. A skipped item only has its home row count read. A hit that lands
// in its home row is written there. Past the home row's slots, the chain of
// links is followed to its tail, and a hit is appended to a tail with room.
// Otherwise a new spare row is sought, one spare range and one row at a
// time; the tail's last entry moves into the spare row and a link to it
// takes its place. Each step is a registered read of a memory followed by a
// check. A finished result waits while the result queue is full. Items
// queue two deep on each side of the sequencer.
// depends on sit_pkg, sit_front, sit_back and sit_resq
`timescale 1ns / 1ps

module seed_index_table_insert (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [14:0]  seed_code,
  input  logic         seed_invalid,
  input  logic [22:0]  sequence_number,
  input  logic [22:0]  seed_position,
  output logic         empty,
  input  logic         pop,
  output logic [1:0]   status,
  output logic [14:0]  stored_row,
  output logic [2:0]   stored_slot,
  output logic [7:0]   home_count,
  input  logic         cfg_write,
  input  logic         skip_repeated_letters
);

  logic              clearing;
  logic              q_pop;
  logic              q_empty;
  sit_pkg::item_t    q_head;
  logic              res_full;
  logic              res_push;
  sit_pkg::result_t  res_data;
  sit_pkg::result_t  head;

  sit_front u_front (
    .clk                   (clk),
    .rst                   (rst),
    .push                  (push),
    .full                  (full),
    .seed_code             (seed_code),
    .seed_invalid          (seed_invalid),
    .sequence_number       (sequence_number),
    .seed_position         (seed_position),
    .cfg_write             (cfg_write),
    .skip_repeated_letters (skip_repeated_letters),
    .clearing              (clearing),
    .q_pop                 (q_pop),
    .q_empty               (q_empty),
    .q_head                (q_head)
  );

  sit_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  sit_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign status      = head.status;
  assign stored_row  = 15'(head.row);
  assign stored_slot = 3'(head.slot);
  assign home_count  = head.home_count;

endmodule

@@ sv/sit_props.sv @@
// port-level checks for the seed index table insert block, bound to the top
// depends on assert_macros.svh and sit_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sit_props (
  input logic         clk,
  input logic         rst,
  input logic         full,
  input logic         empty,
  input logic         pop,
  input logic [1:0]   status,
  input logic [14:0]  stored_row,
  input logic [2:0]   stored_slot,
  input logic [7:0]   home_count
);

  // table clearing follows every reset, so no item is taken right after it
  `SIT_ASSERT_NOW(a_full_after_rst, $past(rst), full)
  // a stored hit always leaves a nonzero home count
  `SIT_ASSERT_NOW(a_stored_count, !empty && status == sit_pkg::ST_STORED, home_count != 8'd0)
  // an item that was not stored reports no location
  `SIT_ASSERT_NOW(a_unstored_loc, !empty && status != sit_pkg::ST_STORED,
                  stored_row == 15'd0 && stored_slot == 3'd0)
  // a waiting item holds until popped
  `SIT_ASSERT_NEXT(a_result_holds, !empty && !pop,
                   !empty && $stable(status) && $stable(stored_row) && $stable(home_count))

endmodule

bind seed_index_table_insert sit_props u_sit_props (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .status      (status),
  .stored_row  (stored_row),
  .stored_slot (stored_slot),
  .home_count  (home_count)
);
